// ===== hw/rtl/tsam_pkg.sv =====
// ----------------------------------------------------------------------------
// tsam_pkg
// shared types, register codes and field helpers for the slice address map
// ----------------------------------------------------------------------------
package tsam_pkg;

    localparam int unsigned OFFSET_BITS   = 24;
    localparam int unsigned FIELD_BITS    = 16;
    localparam int unsigned PACKED_FIELDS = 4;
    localparam int unsigned CFG_DATA_BITS = 64;
    localparam int unsigned NUM_DIMS_BITS = 3;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_NUM_DIMS  = 2'd0,
        CFG_OUT_SHAPE = 2'd1,
        CFG_IN_SHAPE  = 2'd2,
        CFG_BEGIN     = 2'd3
    } t_cfg_reg;

    // stride sequencer states
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_CLEAR,
        SEQ_RUN
    } t_seq_state;

    // sequencer status toward the top level
    typedef struct packed {
        logic busy;
        logic cfg_ready;
    } t_seq_stat;

    // extent or begin of one dimension; dimension 0 sits in the top bits
    function automatic logic [FIELD_BITS-1:0] f_field(
        input logic [CFG_DATA_BITS-1:0] pk,
        input int unsigned              d,
        input logic [FIELD_BITS-1:0]    beyond
    );
        logic [FIELD_BITS-1:0] res;
        if (d >= PACKED_FIELDS) begin
            res = beyond;
        end else begin
            res = pk[FIELD_BITS*(PACKED_FIELDS-1-d) +: FIELD_BITS];
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/tsam_stride_seq.sv =====
// ----------------------------------------------------------------------------
// tsam_stride_seq
// rebuilds the row-major output and input strides after a register write,
// one dimension per cycle from the innermost one outward
// ----------------------------------------------------------------------------
module tsam_stride_seq #(
    parameter int unsigned MAX_DIMS = 4,
    parameter int unsigned W        = 24,
    parameter int unsigned CW       = 3
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_kick,
    input  logic [CW-1:0]                        i_n_act,
    input  logic [tsam_pkg::CFG_DATA_BITS-1:0]   i_out_shape,
    input  logic [tsam_pkg::CFG_DATA_BITS-1:0]   i_in_shape,
    output logic [W-1:0]                         o_out_stride [MAX_DIMS],
    output logic [W-1:0]                         o_in_stride  [MAX_DIMS],
    output tsam_pkg::t_seq_stat                  o_stat
);
    import tsam_pkg::*;

    localparam int unsigned KW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    t_seq_state r_state, n_state;

    logic [CW-1:0]            r_cnt;
    logic [W-1:0]             r_so, r_si;
    logic [W-1:0]             r_out_st [MAX_DIMS];
    logic [W-1:0]             r_in_st  [MAX_DIMS];

    logic                     w_clear, w_step;
    logic [CW-1:0]            w_cnt_dec;
    logic [KW-1:0]            w_k;
    logic [FIELD_BITS-1:0]    w_ext_o, w_ext_i;
    logic [W+FIELD_BITS-1:0]  w_prod_o, w_prod_i;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SEQ_IDLE: begin
                if (i_kick) n_state = SEQ_CLEAR;
            end
            SEQ_CLEAR: begin
                n_state = SEQ_RUN;
            end
            SEQ_RUN: begin
                if (r_cnt <= CW'(1)) n_state = SEQ_IDLE;
            end
            default: begin
                n_state = SEQ_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_stat.busy      = 1'b1;
        o_stat.cfg_ready = 1'b0;
        w_clear          = 1'b0;
        w_step           = 1'b0;
        unique case (r_state)
            SEQ_IDLE: begin
                o_stat.busy      = 1'b0;
                o_stat.cfg_ready = 1'b1;
            end
            SEQ_CLEAR: begin
                w_clear = 1'b1;
            end
            SEQ_RUN: begin
                w_step = (r_cnt != '0);
            end
            default: begin
                w_clear = 1'b0;
            end
        endcase
    end

    assign w_cnt_dec = r_cnt - 1'b1;
    assign w_k       = w_cnt_dec[KW-1:0];
    assign w_ext_o   = f_field(i_out_shape, 32'(w_k), FIELD_BITS'(1));
    assign w_ext_i   = f_field(i_in_shape,  32'(w_k), FIELD_BITS'(1));
    assign w_prod_o  = r_so * w_ext_o;
    assign w_prod_i  = r_si * w_ext_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_cnt   <= '0;
            for (int d = 0; d < MAX_DIMS; d++) begin
                r_out_st[d] <= '0;
                r_in_st[d]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_clear) begin
                r_cnt <= i_n_act;
                for (int d = 0; d < MAX_DIMS; d++) begin
                    r_out_st[d] <= '0;
                    r_in_st[d]  <= '0;
                end
            end else if (w_step) begin
                r_cnt         <= w_cnt_dec;
                r_out_st[w_k] <= r_so;
                r_in_st[w_k]  <= r_si;
            end
        end
    end

    // running products, innermost stride is one
    always_ff @(posedge i_clk) begin
        if (w_clear) begin
            r_so <= W'(1);
            r_si <= W'(1);
        end else if (w_step) begin
            r_so <= w_prod_o[W-1:0];
            r_si <= w_prod_i[W-1:0];
        end
    end

    assign o_out_stride = r_out_st;
    assign o_in_stride  = r_in_st;

endmodule

// ===== hw/rtl/tsam_dim_pipe.sv =====
// ----------------------------------------------------------------------------
// tsam_dim_pipe
// one dimension of the mapping: bit-per-stage restoring divide of the
// remaining offset by the output stride, add begin, scale by input stride
// ----------------------------------------------------------------------------
module tsam_dim_pipe #(
    parameter int unsigned W = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [W-1:0]  i_rem,
    input  logic [W-1:0]  i_src,
    input  logic [W-1:0]  i_div,
    input  logic [W-1:0]  i_mul,
    input  logic [15:0]   i_begin,
    output logic          o_vld,
    output logic [W-1:0]  o_rem,
    output logic [W-1:0]  o_src
);

    // divide stages: w_a holds dividend bits shifting out and quotient bits in
    logic [W-1:0]   w_a [W+1];
    logic [W-1:0]   w_p [W+1];
    logic [W-1:0]   w_s [W+1];
    logic [W:0]     w_v;

    logic [W-1:0]   r_a [W];
    logic [W-1:0]   r_p [W];
    logic [W-1:0]   r_s [W];
    logic [W-1:0]   r_v;

    assign w_a[0] = i_rem;
    assign w_p[0] = '0;
    assign w_s[0] = i_src;
    assign w_v[0] = i_vld;

    for (genvar j = 0; j < W; j++) begin : g_div
        logic [W:0] w_t, w_d;
        logic       w_ge;

        assign w_t  = {w_p[j], w_a[j][W-1]};
        assign w_ge = (w_t >= {1'b0, i_div});
        assign w_d  = w_t - {1'b0, i_div};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else begin
                r_v[j] <= w_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_a[j] <= {w_a[j][W-2:0], w_ge};
            r_p[j] <= w_ge ? w_d[W-1:0] : w_t[W-1:0];
            r_s[j] <= w_s[j];
        end

        assign w_a[j+1] = r_a[j];
        assign w_p[j+1] = r_p[j];
        assign w_s[j+1] = r_s[j];
        assign w_v[j+1] = r_v[j];
    end

    // a zero stride gives coordinate zero; the remainder already passes whole
    logic [W-1:0]    w_q;
    logic [W-1:0]    r_coord, r_c_rem, r_c_src;
    logic            r_c_v;
    logic [2*W-1:0]  w_prod;
    logic [W-1:0]    r_prod, r_m_rem, r_m_src;
    logic            r_m_v;
    logic [W-1:0]    r_o_rem, r_o_src;
    logic            r_o_v;

    assign w_q    = (i_div == '0) ? '0 : w_a[W];
    assign w_prod = r_coord * i_mul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
            r_m_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            r_c_v <= w_v[W];
            r_m_v <= r_c_v;
            r_o_v <= r_m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_coord <= W'(32'(w_q) + 32'(i_begin));
        r_c_rem <= w_p[W];
        r_c_src <= w_s[W];
        r_prod  <= w_prod[W-1:0];
        r_m_rem <= r_c_rem;
        r_m_src <= r_c_src;
        r_o_src <= r_m_src + r_prod;
        r_o_rem <= r_m_rem;
    end

    assign o_vld = r_o_v;
    assign o_rem = r_o_rem;
    assign o_src = r_o_src;

endmodule

// ===== hw/rtl/tensor_slice_address_map.sv =====
// ----------------------------------------------------------------------------
// tensor_slice_address_map
// throughput: one word per cycle while busy is low; each dimension is
//   a fixed chain of INDEX_BITS divide stages, a begin add, a multiply
//   and an accumulate
// after a register write busy stays high while the stride sequencer
//   rebuilds both stride tables, one dimension a cycle
// synchronous active-low reset clears configuration registers, strides and valid bits;
//   results leave on a one-cycle strobe that the receiver cannot hold off
// ----------------------------------------------------------------------------
module tensor_slice_address_map #(
    parameter int unsigned MAX_DIMS   = 4,
    parameter int unsigned INDEX_BITS = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // command side
    input  logic                                 start,
    output logic                                 busy,
    input  logic [tsam_pkg::OFFSET_BITS-1:0]     i_out_offset,
    // result side
    output logic                                 o_res_strobe,
    output logic [tsam_pkg::OFFSET_BITS-1:0]     o_src_offset,
    output logic                                 o_valid_res,
    // configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  tsam_pkg::t_cfg_reg                   i_cfg_index,
    input  logic [tsam_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import tsam_pkg::*;

    localparam int unsigned CW  = $clog2(MAX_DIMS + 1);
    localparam int unsigned LAT = MAX_DIMS * (INDEX_BITS + 3) + 1;

    // configuration registers
    logic [NUM_DIMS_BITS-1:0]  r_num_dims;
    logic [CFG_DATA_BITS-1:0]  r_out_shape, r_in_shape, r_begin;

    logic                      w_accept, w_cfg_wr;
    logic [CW-1:0]             w_n_act;
    t_seq_stat                 w_stat;

    logic [INDEX_BITS-1:0]     w_out_stride [MAX_DIMS];
    logic [INDEX_BITS-1:0]     w_in_stride  [MAX_DIMS];

    // ready side: held off during reset and while strides rebuild
    assign busy        = w_stat.busy | ~i_rst_n;
    assign o_cfg_ready = w_stat.cfg_ready & i_rst_n;
    assign w_accept    = start & ~busy;
    assign w_cfg_wr    = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims  <= '0;
            r_out_shape <= '0;
            r_in_shape  <= '0;
            r_begin     <= '0;
        end else if (w_cfg_wr) begin
            unique case (i_cfg_index)
                CFG_NUM_DIMS:  r_num_dims  <= i_cfg_data[NUM_DIMS_BITS-1:0];
                CFG_OUT_SHAPE: r_out_shape <= i_cfg_data;
                CFG_IN_SHAPE:  r_in_shape  <= i_cfg_data;
                CFG_BEGIN:     r_begin     <= i_cfg_data;
                default:       r_begin     <= r_begin;
            endcase
        end
    end

    // dimension count saturates at the number of built dimensions
    assign w_n_act = ({1'b0, r_num_dims} > (NUM_DIMS_BITS+1)'(MAX_DIMS)) ?
                     CW'(MAX_DIMS) : CW'(r_num_dims);

    tsam_stride_seq #(
        .MAX_DIMS (MAX_DIMS),
        .W        (INDEX_BITS),
        .CW       (CW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_kick       (w_cfg_wr),
        .i_n_act      (w_n_act),
        .i_out_shape  (r_out_shape),
        .i_in_shape   (r_in_shape),
        .o_out_stride (w_out_stride),
        .o_in_stride  (w_in_stride),
        .o_stat       (w_stat)
    );

    // dimension chain; inactive dimensions have zero strides and add nothing
    logic                    w_vld [MAX_DIMS+1];
    logic [INDEX_BITS-1:0]   w_rem [MAX_DIMS+1];
    logic [INDEX_BITS-1:0]   w_src [MAX_DIMS+1];

    assign w_vld[0] = w_accept;
    assign w_rem[0] = INDEX_BITS'(i_out_offset);
    assign w_src[0] = '0;

    for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
        tsam_dim_pipe #(
            .W (INDEX_BITS)
        ) u_dim (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[d]),
            .i_rem   (w_rem[d]),
            .i_src   (w_src[d]),
            .i_div   (w_out_stride[d]),
            .i_mul   (w_in_stride[d]),
            .i_begin (f_field(r_begin, d, '0)),
            .o_vld   (w_vld[d+1]),
            .o_rem   (w_rem[d+1]),
            .o_src   (w_src[d+1])
        );
    end

    // output register; no active dimension gives a zero, invalid result
    logic                    r_res_strobe, r_valid_res;
    logic [OFFSET_BITS-1:0]  r_src_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_strobe <= 1'b0;
        end else begin
            r_res_strobe <= w_vld[MAX_DIMS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_valid_res  <= (w_n_act != '0);
        r_src_offset <= (w_n_act == '0) ? '0 : OFFSET_BITS'(w_src[MAX_DIMS]);
    end

    assign o_res_strobe = r_res_strobe;
    assign o_src_offset = r_src_offset;
    assign o_valid_res  = r_valid_res;

    // every accepted word comes out after the fixed pipeline depth
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LAT o_res_strobe)
        else $error("result strobe missing after pipeline latency");

    // no result without a word accepted exactly one latency earlier
    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> $past(w_accept, LAT))
        else $error("result strobe without matching accepted word");

    // a register write must hold off new words while strides rebuild
    a_kick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> busy)
        else $error("busy not raised after configuration write");

    // disabled mapping gives a zero offset
    a_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && !o_valid_res) |-> (o_src_offset == '0))
        else $error("nonzero offset with no active dimension");

endmodule

// ===== verif/tb_tensor_slice_address_map.sv =====
// ----------------------------------------------------------------------------
// tb_tensor_slice_address_map
// self-checking bench for the slice address map. directed phases hit the
// disabled, saturated, zero-stride and wrapping settings; random phases then
// reprogram shapes and begins and send offsets mostly inside the output
// tensor. every result word is checked against an in-bench address predictor
// ----------------------------------------------------------------------------
module tb_tensor_slice_address_map;
    import tsam_pkg::*;

    localparam int unsigned DIMS            = 4;
    localparam int unsigned IDX_W           = OFFSET_BITS;
    localparam int unsigned LATENCY         = DIMS * (IDX_W + 3) + 1;
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned RAND_PHASES     = 17;
    localparam int unsigned WORDS_PER_PHASE = 50;

    typedef logic [IDX_W-1:0] t_idx;

    // one expected result word
    typedef struct packed {
        t_idx src;
        logic valid;
    } t_src_word;

    // dut signals, all inputs known from time zero
    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     start        = 1'b0;
    logic                     busy;
    t_idx                     i_out_offset = '0;
    logic                     o_res_strobe;
    t_idx                     o_src_offset;
    logic                     o_valid_res;
    logic                     i_cfg_valid  = 1'b0;
    logic                     o_cfg_ready;
    t_cfg_reg                 i_cfg_index  = CFG_NUM_DIMS;
    logic [CFG_DATA_BITS-1:0] i_cfg_data   = '0;

    tensor_slice_address_map #(
        .MAX_DIMS  (DIMS),
        .INDEX_BITS(IDX_W)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_out_offset(i_out_offset),
        .o_res_strobe(o_res_strobe),
        .o_src_offset(o_src_offset),
        .o_valid_res (o_valid_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // address predictor: shadow registers and stride tables
    // ------------------------------------------------------------------------
    logic [2:0]  map_ndims;
    logic [63:0] map_out_shape;
    logic [63:0] map_in_shape;
    logic [63:0] map_begin;
    t_idx        out_stride [DIMS];
    t_idx        in_stride  [DIMS];

    // dimension 0 lives in the top 16 bits
    function automatic logic [15:0] field_at(input logic [63:0] pk, input int d);
        return pk[16*(3-d) +: 16];
    endfunction

    // dense row-major strides, innermost active dimension has stride 1
    function automatic void rebuild_strides();
        int   n;
        t_idx so;
        t_idx si;
        n  = (map_ndims > DIMS) ? DIMS : map_ndims;
        so = 1;
        si = 1;
        for (int d = 0; d < DIMS; d++) begin
            out_stride[d] = '0;
            in_stride[d]  = '0;
        end
        for (int k = n - 1; k >= 0; k--) begin
            out_stride[k] = so;
            in_stride[k]  = si;
            // products wrap at the index width
            so = so * t_idx'(field_at(map_out_shape, k));
            si = si * t_idx'(field_at(map_in_shape, k));
        end
    endfunction

    function automatic void apply_cfg(input t_cfg_reg r, input logic [63:0] v);
        case (r)
            CFG_NUM_DIMS:  map_ndims     = v[2:0];
            CFG_OUT_SHAPE: map_out_shape = v;
            CFG_IN_SHAPE:  map_in_shape  = v;
            CFG_BEGIN:     map_begin     = v;
            default: ;
        endcase
        rebuild_strides();
    endfunction

    // peel coordinates off the output offset, shift by begin, re-linearize
    function automatic t_src_word predict_src(input t_idx off);
        int        n;
        t_idx      rem;
        t_idx      acc;
        t_idx      coord;
        t_src_word w;
        n   = (map_ndims > DIMS) ? DIMS : map_ndims;
        rem = off;
        acc = '0;
        if (n == 0) begin
            // mapping disabled
            w.src   = '0;
            w.valid = 1'b0;
            return w;
        end
        for (int d = 0; d < n; d++) begin
            coord = '0;
            // a zero stride leaves the coordinate at 0 and the remainder as is
            if (out_stride[d] != 0) begin
                coord = rem / out_stride[d];
                rem   = rem % out_stride[d];
            end
            coord = coord + t_idx'(field_at(map_begin, d));
            acc   = acc + coord * in_stride[d];
        end
        w.src   = acc;
        w.valid = 1'b1;
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // queues and run state
    // ------------------------------------------------------------------------
    t_idx        offset_backlog [$];  // offsets waiting to be sent
    t_src_word   src_pending    [$];  // predicted words not yet seen
    int          gap_odds     = 3;    // one idle burst per that many words, 0 = none
    int          cfg_gap_odds = 3;
    logic        hold_off     = 1'b0; // sender pause requested by the sequencer
    int          gap_left     = 0;
    int unsigned words_sent   = 0;
    int unsigned words_checked = 0;
    int unsigned errors       = 0;
    int unsigned phases_run   = 0;
    int unsigned cycle_count  = 0;

    // ------------------------------------------------------------------------
    // driver: offers offsets on start, predicts at the accepting edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic next_start;
        t_idx next_off;
        next_start = start;
        next_off   = i_out_offset;
        if (!i_rst_n) begin
            next_start = 1'b0;
        end else begin
            if (start && !busy) begin
                src_pending.push_back(predict_src(i_out_offset));
                words_sent++;
                next_start = 1'b0;
                // random idle burst after this word
                if (gap_odds != 0 && $urandom_range(gap_odds - 1) == 0) begin
                    gap_left = $urandom_range(4, 1);
                end
            end
            // a pending offer stays up until busy drops
            if (!next_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!hold_off && offset_backlog.size() > 0) begin
                    next_off   = offset_backlog.pop_front();
                    next_start = 1'b1;
                end
            end
        end
        start        <= next_start;
        i_out_offset <= next_off;
    end

    // ------------------------------------------------------------------------
    // monitor: strobed result words against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_src_word exp_w;
        if (i_rst_n && o_res_strobe) begin
            if (src_pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, actual src_offset=%h valid_res=%b",
                         $time, o_src_offset, o_valid_res);
            end else begin
                exp_w = src_pending.pop_front();
                if (o_src_offset !== exp_w.src || o_valid_res !== exp_w.valid) begin
                    errors++;
                    $display("%0t: word %0d mismatch, expected src_offset=%h valid_res=%b, %s%h %s%b",
                             $time, words_checked, exp_w.src, exp_w.valid,
                             "actual src_offset=", o_src_offset, "valid_res=", o_valid_res);
                end
                words_checked++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** tensor_slice_address_map: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // configuration and phase sequencing
    // ------------------------------------------------------------------------
    // one register write on the config channel, waits for ready
    task automatic write_reg(input t_cfg_reg r, input logic [63:0] v);
        int pause;
        pause = (cfg_gap_odds != 0 && $urandom_range(cfg_gap_odds - 1) == 0)
                ? $urandom_range(4, 1) : 0;
        repeat (pause) @(posedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_cfg(r, v);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input logic [63:0] nd, input logic [63:0] os,
                            input logic [63:0] is, input logic [63:0] bg);
        write_reg(CFG_NUM_DIMS, nd);
        write_reg(CFG_OUT_SHAPE, os);
        write_reg(CFG_IN_SHAPE, is);
        write_reg(CFG_BEGIN, bg);
        // back to the negative edge before feeding the backlog
        @(negedge i_clk);
    endtask

    // block idle: nothing queued, nothing offered, nothing outstanding
    task automatic drain();
        do @(negedge i_clk);
        while (offset_backlog.size() != 0 || start || src_pending.size() != 0);
        phases_run++;
    endtask

    // random offsets, mostly inside the current output tensor
    task automatic fill_random(input int count);
        int              n;
        longint unsigned span;
        n    = (map_ndims > DIMS) ? DIMS : map_ndims;
        span = 1;
        for (int d = 0; d < n; d++) begin
            span = span * field_at(map_out_shape, d);
        end
        for (int i = 0; i < count; i++) begin
            if (n != 0 && span != 0 && span <= (64'd1 << IDX_W) && $urandom_range(99) < 85)
            begin
                offset_backlog.push_back(t_idx'($urandom_range(32'(span - 1))));
            end else begin
                offset_backlog.push_back(t_idx'($urandom));
            end
        end
    endtask

    // one random 16-bit extent, mostly small
    function automatic logic [15:0] rand_extent();
        int sel;
        sel = $urandom_range(99);
        if (sel < 75) return 16'($urandom_range(12, 1));
        if (sel < 83) return 16'h0;
        if (sel < 93) return 16'($urandom);
        return 16'hFFFF;
    endfunction

    initial begin
        logic [63:0] nd;
        logic [63:0] os;
        logic [63:0] is;
        logic [63:0] bg;
        logic [15:0] ext;

        map_ndims     = '0;
        map_out_shape = '0;
        map_in_shape  = '0;
        map_begin     = '0;
        rebuild_strides();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset state: no dimensions, mapping disabled
        offset_backlog.push_back(24'h000000);
        offset_backlog.push_back(24'hFFFFFF);
        offset_backlog.push_back(t_idx'($urandom));
        drain();

        // two dimensions, small slice of a 7x9 input
        set_regs(64'd2, {16'd3, 16'd5, 16'd0, 16'd0},
                 {16'd7, 16'd9, 16'd0, 16'd0}, {16'd2, 16'd1, 16'd0, 16'd0});
        offset_backlog.push_back(24'd0);
        offset_backlog.push_back(24'd7);
        offset_backlog.push_back(24'd14);
        offset_backlog.push_back(24'hFFFFFF);
        drain();

        // dimension count above the maximum saturates, all-ones shapes wrap
        set_regs('1, '1, '1, '1);
        offset_backlog.push_back(24'h000000);
        offset_backlog.push_back(24'hFFFFFF);
        offset_backlog.push_back(24'h123456);
        drain();

        // zero extent gives a zero output stride on the outer dimension
        set_regs(64'd3, {16'd4, 16'd0, 16'd6, 16'd0},
                 {16'd5, 16'd5, 16'd8, 16'd0}, {16'd1, 16'd2, 16'd3, 16'd0});
        offset_backlog.push_back(24'd0);
        offset_backlog.push_back(24'd5);
        offset_backlog.push_back(24'd100);
        offset_backlog.push_back(24'hFFFFFF);
        drain();

        // single dimension, begin add wraps the offset
        set_regs(64'd1, 64'd0, 64'd0, {16'h8000, 16'd0, 16'd0, 16'd0});
        offset_backlog.push_back(24'h000000);
        offset_backlog.push_back(24'hFFFFFF);
        offset_backlog.push_back(24'h7FFFFF);
        drain();

        // four dimensions, input strides overflow to zero
        set_regs(64'd4, {16'd2, 16'd3, 16'd4, 16'd5},
                 {16'h1000, 16'h1000, 16'h1000, 16'h1000}, {16'd1, 16'd1, 16'd1, 16'd1});
        offset_backlog.push_back(24'd0);
        offset_backlog.push_back(24'd119);
        offset_backlog.push_back(24'd60);
        offset_backlog.push_back(24'hFFFFFF);
        drain();

        // explicit disable with live shapes behind it
        set_regs({$urandom, $urandom} & ~64'h7, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
        offset_backlog.push_back(t_idx'($urandom));
        offset_backlog.push_back(24'hFFFFFF);
        drain();

        // random settings; the last two phases run without idling
        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p >= RAND_PHASES - 2) begin
                gap_odds     = 0;
                cfg_gap_odds = 0;
            end else begin
                case ($urandom_range(2))
                    0: gap_odds = 0;
                    1: gap_odds = 3;
                    default: gap_odds = 6;
                endcase
                cfg_gap_odds = 3;
            end
            // dimension count, upper data bits are noise
            nd = {$urandom, $urandom};
            if ($urandom_range(9) < 7) begin
                nd[2:0] = 3'($urandom_range(4, 1));
            end
            for (int d = 0; d < 4; d++) begin
                ext = rand_extent();
                os[16*(3-d) +: 16] = ext;
                if ($urandom_range(9) < 8) begin
                    is[16*(3-d) +: 16] = ext + 16'($urandom_range(8));
                    bg[16*(3-d) +: 16] = 16'($urandom_range(8));
                end else begin
                    is[16*(3-d) +: 16] = 16'($urandom);
                    bg[16*(3-d) +: 16] = 16'($urandom);
                end
            end
            set_regs(nd, os, is, bg);
            fill_random(WORDS_PER_PHASE);
            // now and then the sender stops until the pipeline is empty
            if (p % 4 == 1) begin
                while (offset_backlog.size() > WORDS_PER_PHASE / 2) @(negedge i_clk);
                hold_off = 1'b1;
                while (start || src_pending.size() != 0) @(negedge i_clk);
                hold_off = 1'b0;
            end
            drain();
        end

        // let any stray word surface
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("run covered %0d phases, %0d offsets sent, %0d result words checked",
                 phases_run, words_sent, words_checked);
        $display("settings: disabled, saturated and full dimension counts, zero and wrapping strides");
        if (errors == 0) begin
            $display("** tensor_slice_address_map: PASSED **");
        end else begin
            $display("** tensor_slice_address_map: FAILED **");
        end
        $finish;
    end

endmodule
